// File: hdl/k_permutation_generator_macros.svh
// Assertion macros shared by the k_permutation_generator RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef K_PERMUTATION_GENERATOR_MACROS_SVH
`define K_PERMUTATION_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define KPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define KPG_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KPG_ASSERT(name, prop, msg)
`define KPG_ASSERT_NORST(name, prop, msg)
`endif

`endif

// File: hdl/kpg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the k-permutation generator.
// No dependencies; used by kpg_ctrl, kpg_dpath and the top level.
package kpg_pkg;

  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned WLEN_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [LETTER_W-1:0] ALPHABET_RST = 5'd26;
  localparam logic [WLEN_W-1:0]   WLEN_RST     = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHABET_SIZE = 2'd0,
    CFG_WORD_LENGTH   = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_FILL,
    OP_BACK,
    OP_EMIT,
    OP_EXH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_hit;    // register write this cycle
    logic length_ok;  // word length is nonzero and fits the alphabet and the word store
    logic pos_last;   // position pointer at word_length - 1
    logic pos_zero;   // position pointer at 0
    logic found;      // letter search hit
    logic out_free;   // output register can take a beat
  } dp_status_t;

endpackage

// File: hdl/kpg_dpath.sv
`timescale 1ns / 1ps
// Datapath: config registers, used-letter mask, current word, letter search
// unit and output register. Depends on kpg_pkg and the assertion macros.
`include "k_permutation_generator_macros.svh"

module kpg_dpath #(
  parameter int unsigned MaxAlphabet = 26,
  parameter int unsigned MaxLength   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [kpg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kpg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [kpg_pkg::LETTER_W-1:0]        letter_o,
  output logic                                last_letter_o,
  output logic                                exhausted_o,
  input  kpg_pkg::dp_cmd_t                    cmd_i,
  output kpg_pkg::dp_status_t                 status_o
);

  localparam int unsigned PosW = (MaxLength > 1) ? $clog2(MaxLength) : 1;

  logic [kpg_pkg::LETTER_W-1:0] alpha_q;
  logic [kpg_pkg::WLEN_W-1:0]   wlen_q;
  logic [MaxAlphabet-1:0]       used_q;
  logic [kpg_pkg::LETTER_W-1:0] word_q [MaxLength];
  logic [PosW-1:0]              pos_q;
  logic                         out_valid_q;
  logic [kpg_pkg::LETTER_W-1:0] letter_q;
  logic                         last_q;
  logic                         exh_q;

  logic [kpg_pkg::LETTER_W-1:0] eff_alpha;
  logic                         length_ok;
  logic                         pos_last;
  logic                         pos_zero;
  logic                         cfg_hit;
  logic                         out_free;
  logic                         back;
  logic [kpg_pkg::LETTER_W-1:0] cur;
  logic [MaxAlphabet-1:0]       cur_bit;
  logic [MaxAlphabet-1:0]       used_srch;
  logic [MaxAlphabet-1:0]       cand;
  logic [kpg_pkg::LETTER_W-1:0] found_idx;
  logic [MaxAlphabet-1:0]       pick_bit;
  logic                         found;
  logic [PosW-1:0]              pos_adv;
  logic                         load_letter;
  logic                         load_exh;

  assign eff_alpha = (alpha_q > kpg_pkg::LETTER_W'(MaxAlphabet)) ?
                     kpg_pkg::LETTER_W'(MaxAlphabet) : alpha_q;
  assign length_ok = (wlen_q != '0) && (wlen_q <= kpg_pkg::WLEN_W'(MaxLength)) &&
                     ({1'b0, wlen_q} <= eff_alpha);
  assign pos_last  = (kpg_pkg::WLEN_W'(pos_q) + kpg_pkg::WLEN_W'(1)) == wlen_q;
  assign pos_zero  = (pos_q == '0);
  assign cfg_hit   = cfg_valid_i && ((cfg_index_i == kpg_pkg::CFG_ALPHABET_SIZE) ||
                                     (cfg_index_i == kpg_pkg::CFG_WORD_LENGTH));
  assign out_free  = !out_valid_q || out_ready_i;
  assign back      = (cmd_i.op == kpg_pkg::OP_BACK);

  assign cur       = word_q[pos_q];
  assign cur_bit   = MaxAlphabet'(1) << cur;
  // Backtracking frees the letter at this position before searching above it.
  assign used_srch = back ? (used_q & ~cur_bit) : used_q;

  always_comb begin
    cand      = '0;
    found_idx = '0;
    for (int c = 0; c < MaxAlphabet; c++) begin
      cand[c] = !used_srch[c] && (kpg_pkg::LETTER_W'(c) < eff_alpha) &&
                (!back || (kpg_pkg::LETTER_W'(c) > cur));
    end
    for (int c = MaxAlphabet - 1; c >= 0; c--) begin
      if (cand[c]) begin
        found_idx = kpg_pkg::LETTER_W'(c);
      end
    end
  end

  assign found    = |cand;
  assign pick_bit = MaxAlphabet'(1) << found_idx;
  // Filling the last position wraps the pointer to 0, ready for emission.
  assign pos_adv  = pos_last ? '0 : pos_q + PosW'(1);

  assign load_letter = (cmd_i.op == kpg_pkg::OP_EMIT) && out_free;
  assign load_exh    = (cmd_i.op == kpg_pkg::OP_EXH) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= kpg_pkg::ALPHABET_RST;
      wlen_q      <= kpg_pkg::WLEN_RST;
      used_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxLength; i++) begin
        word_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        kpg_pkg::OP_START: begin
          used_q <= '0;
          pos_q  <= '0;
          for (int i = 0; i < MaxLength; i++) begin
            word_q[i] <= '0;
          end
        end
        kpg_pkg::OP_FILL: begin
          word_q[pos_q] <= found_idx;
          used_q        <= used_q | pick_bit;
          pos_q         <= pos_adv;
        end
        kpg_pkg::OP_BACK: begin
          if (found) begin
            word_q[pos_q] <= found_idx;
            used_q        <= used_srch | pick_bit;
            pos_q         <= pos_adv;
          end else begin
            used_q <= used_srch;
            if (!pos_zero) begin
              pos_q <= pos_q - PosW'(1);
            end
          end
        end
        kpg_pkg::OP_EMIT: begin
          if (out_free && !pos_last) begin
            pos_q <= pos_q + PosW'(1);
          end
        end
        kpg_pkg::OP_EXH: begin
          if (out_free) begin
            used_q <= '0;
            for (int i = 0; i < MaxLength; i++) begin
              word_q[i] <= '0;
            end
          end
        end
        default: ;
      endcase

      if (load_letter || load_exh) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_hit) begin
        if (cfg_index_i == kpg_pkg::CFG_ALPHABET_SIZE) begin
          alpha_q <= cfg_data_i;
        end else begin
          wlen_q <= cfg_data_i[kpg_pkg::WLEN_W-1:0];
        end
        used_q <= '0;
        for (int i = 0; i < MaxLength; i++) begin
          word_q[i] <= '0;
        end
      end
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_letter) begin
      letter_q <= cur;
      last_q   <= pos_last;
      exh_q    <= 1'b0;
    end else if (load_exh) begin
      letter_q <= '0;
      last_q   <= 1'b1;
      exh_q    <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign letter_o      = letter_q;
  assign last_letter_o = last_q;
  assign exhausted_o   = exh_q;

  assign status_o.cfg_hit   = cfg_hit;
  assign status_o.length_ok = length_ok;
  assign status_o.pos_last  = pos_last;
  assign status_o.pos_zero  = pos_zero;
  assign status_o.found     = found;
  assign status_o.out_free  = out_free;

  `KPG_ASSERT(a_exh_beat,
              (out_valid_q && exh_q) |-> (letter_q == '0 && last_q),
              "exhausted beat must carry letter 0 and last")
  `KPG_ASSERT(a_load_src,
              $rose(out_valid_q) |-> ($past(cmd_i.op) == kpg_pkg::OP_EMIT ||
                                      $past(cmd_i.op) == kpg_pkg::OP_EXH),
              "output loaded without emit or exhaust command")
  `KPG_ASSERT_NORST(a_rst_out, !rst_ni |-> !out_valid_q, "output valid during reset")

endmodule

// File: hdl/kpg_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences start, fill, backtrack, emit and exhaust steps and
// keeps the started and done flags. Depends on kpg_pkg and the macros.
`include "k_permutation_generator_macros.svh"

module kpg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output kpg_pkg::dp_cmd_t    cmd_o,
  input  kpg_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_BACK,
    S_EMIT,
    S_EXH
  } state_e;

  state_e state_q;
  logic   started_q;
  logic   done_q;
  logic   accept;
  logic   fresh;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // First request after reset or a register write behaves as a restart.
  assign fresh      = restart_i || !started_q;

  always_comb begin
    unique case (state_q)
      S_IDLE:  cmd_o.op = (accept && fresh) ? kpg_pkg::OP_START : kpg_pkg::OP_NOP;
      S_FILL:  cmd_o.op = kpg_pkg::OP_FILL;
      S_BACK:  cmd_o.op = kpg_pkg::OP_BACK;
      S_EMIT:  cmd_o.op = kpg_pkg::OP_EMIT;
      S_EXH:   cmd_o.op = kpg_pkg::OP_EXH;
      default: cmd_o.op = kpg_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (fresh) begin
              started_q <= 1'b1;
              done_q    <= 1'b0;
              state_q   <= status_i.length_ok ? S_FILL : S_EXH;
            end else if (done_q || !status_i.length_ok) begin
              state_q <= S_EXH;
            end else begin
              state_q <= S_BACK;
            end
          end
        end
        S_FILL: begin
          if (status_i.pos_last) begin
            state_q <= S_EMIT;
          end
        end
        S_BACK: begin
          if (status_i.found) begin
            state_q <= status_i.pos_last ? S_EMIT : S_FILL;
          end else if (status_i.pos_zero) begin
            state_q <= S_EXH;
          end
        end
        S_EMIT: begin
          if (status_i.out_free && status_i.pos_last) begin
            state_q <= S_IDLE;
          end
        end
        S_EXH: begin
          if (status_i.out_free) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (status_i.cfg_hit) begin
        started_q <= 1'b0;
        done_q    <= 1'b0;
      end
    end
  end

  `KPG_ASSERT(a_back_exh,
              (state_q == S_BACK && !status_i.found && status_i.pos_zero) |=> state_q == S_EXH,
              "backtrack ran out without exhausting")
  `KPG_ASSERT(a_exh_done,
              (state_q == S_EXH && status_i.out_free && !status_i.cfg_hit) |=>
              (done_q && state_q == S_IDLE),
              "exhaust beat did not mark done")
  `KPG_ASSERT(a_start_src,
              (cmd_o.op == kpg_pkg::OP_START) |-> (state_q == S_IDLE && in_valid_i),
              "start issued without an accepted request")

endmodule

// File: hdl/k_permutation_generator.sv
`timescale 1ns / 1ps
// Lexicographic k-permutation generator: each request beat returns the next
// arrangement of word_length distinct letters from the first alphabet_size
// letters, one letter per output beat with the final one flagged, or a single
// exhausted beat. A request that starts over (restart, or the first one after
// reset or a register write) clears the word, fills each position in turn and
// then emits the word. An advance backtracks from the last position until a
// letter can move up, refills the positions after it and emits the word. An
// exhausted beat follows directly when the generator is done or the length
// is invalid, or once backtracking runs out of positions. The letter search
// unit settles one word position per cycle, and the single output register
// takes one beat per cycle while the output is not stalled. The next request
// is taken while the final beat waits at the output.
// Depends on kpg_pkg, kpg_ctrl and kpg_dpath.

module k_permutation_generator #(
  parameter int unsigned MAX_ALPHABET = 26,
  parameter int unsigned MAX_LENGTH   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kpg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kpg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kpg_pkg::LETTER_W-1:0]    letter_o,
  output logic                            last_letter_o,
  output logic                            exhausted_o
);

  kpg_pkg::dp_cmd_t    cmd;
  kpg_pkg::dp_status_t status;

  // Register writes are always accepted.
  assign cfg_ready_o = 1'b1;

  kpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  kpg_dpath #(
    .MaxAlphabet (MAX_ALPHABET),
    .MaxLength   (MAX_LENGTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .letter_o      (letter_o),
    .last_letter_o (last_letter_o),
    .exhausted_o   (exhausted_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
